### rtl/rbv_pkg.sv
package rbv_pkg;

  localparam int IN_WIDTH   = 32;
  localparam int MAG_W      = 30;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int FRONT_LAT  = 6;
  localparam int UNIT_LAT   = SQRT_STEPS + DIV_STEPS;
  localparam int BACK_LAT   = SQRT_STEPS + 8;

  localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;

  typedef logic signed [31:0] q30_t;

  typedef struct packed {
    logic vld;
    logic dgn;
  } ctl_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } smv_t;

  typedef struct packed {
    logic [63:0] n2;
    smv_t        sm;
  } vec_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [30:0] nlo;
    logic [30:0] quo;
  } div_t;

  function automatic logic [6:0] bit_len64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [MAG_W-1:0] scale_mag(input logic [63:0] m, input logic [6:0] n);
    logic [63:0] s;
    if (n > 7'd30) s = m >> (n - 7'd30);
    else s = m << (7'd30 - n);
    return s[MAG_W-1:0];
  endfunction

  // largest magnitude lands in [2^29, 2^30)
  function automatic smv_t smv_scale(input logic [2:0][63:0] m, input logic [2:0] ng);
    logic [63:0] mx;
    logic [6:0]  n;
    smv_t        o;
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    n = bit_len64(mx);
    for (int i = 0; i < 3; i++) begin
      o.mag[i] = scale_mag(m[i], n);
    end
    o.neg = ng;
    return o;
  endfunction

  function automatic smv_t smv_prep(input logic [2:0][IN_WIDTH-1:0] raw);
    logic [2:0][63:0]    m;
    logic [2:0]          ng;
    logic [IN_WIDTH-1:0] t;
    for (int i = 0; i < 3; i++) begin
      ng[i] = raw[i][IN_WIDTH-1];
      t = ~raw[i] + 1'b1;
      m[i] = ng[i] ? 64'(t) : 64'(raw[i]);
    end
    return smv_scale(m, ng);
  endfunction

  function automatic sq_t sqrt_step(input sq_t a, input int k);
    logic [63:0] b;
    logic [63:0] t;
    sq_t         o;
    b = 64'd1 << (62 - 2 * k);
    t = a.r + b;
    o = a;
    if (a.x >= t) begin
      o.x = a.x - t;
      o.r = (a.r >> 1) + b;
    end else begin
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  function automatic div_t div_init(input logic [MAG_W-1:0] m, input logic [30:0] len);
    logic [60:0] n;
    div_t        o;
    n = 61'({m, 30'b0}) + 61'(len[30:1]);
    o.rem = {1'b0, n[60:31]};
    o.nlo = n[30:0];
    o.quo = '0;
    return o;
  endfunction

  function automatic div_t div_step(input div_t a, input logic [30:0] len);
    logic [31:0] r2;
    logic        qb;
    div_t        o;
    r2 = {a.rem, a.nlo[30]};
    qb = (r2 >= {1'b0, len});
    if (qb) r2 = r2 - {1'b0, len};
    o.rem = r2[30:0];
    o.nlo = {a.nlo[29:0], 1'b0};
    o.quo = {a.quo[29:0], qb};
    return o;
  endfunction

  // floor((x + 2^29) / 2^30)
  function automatic logic signed [34:0] rnd30(input logic signed [63:0] x);
    logic signed [64:0] y;
    y = (65'(x) + 65'sd536870912) >>> 30;
    return y[34:0];
  endfunction

  function automatic q30_t clamp_one(input logic signed [34:0] v);
    if (v > 35'sd1073741824) return Q_ONE;
    if (v < -35'sd1073741824) return -Q_ONE;
    return v[31:0];
  endfunction

endpackage

### rtl/rbv_front.sv
module rbv_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic [2:0][rbv_pkg::IN_WIDTH-1:0] a_i,
  input  logic [2:0][rbv_pkg::IN_WIDTH-1:0] b_i,
  output rbv_pkg::ctl_t                     ctl_o,
  output rbv_pkg::vec_t                     vec_o [3]
);
  import rbv_pkg::*;

  ctl_t ctl_q [FRONT_LAT];

  smv_t sa_d, sb_d;
  logic zero_d;
  smv_t sa1_q, sb1_q;

  logic signed [30:0] ra [3];
  logic signed [30:0] rb [3];
  logic signed [61:0] p_d [6];
  logic signed [61:0] p2_q [6];
  smv_t sa2_q, sb2_q;

  logic signed [62:0] w [3];
  logic               wz_d;
  logic [2:0][61:0]   mw_d;
  logic [2:0]         nw_d;
  logic [2:0][61:0]   mw3_q;
  logic [2:0]         nw3_q;
  smv_t sa3_q, sb3_q;

  logic [2:0][63:0] mwx;
  smv_t sm4_q [3];

  logic [59:0] sq5_q [3][3];
  smv_t sm5_q [3];

  vec_t vec6_q [3];

  always_comb begin
    sa_d = smv_prep(a_i);
    sb_d = smv_prep(b_i);
    zero_d = (a_i == '0) || (b_i == '0);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ra[i] = sa1_q.neg[i] ? -$signed({1'b0, sa1_q.mag[i]}) : $signed({1'b0, sa1_q.mag[i]});
      rb[i] = sb1_q.neg[i] ? -$signed({1'b0, sb1_q.mag[i]}) : $signed({1'b0, sb1_q.mag[i]});
    end
    p_d[0] = ra[1] * rb[2];
    p_d[1] = ra[2] * rb[1];
    p_d[2] = ra[2] * rb[0];
    p_d[3] = ra[0] * rb[2];
    p_d[4] = ra[0] * rb[1];
    p_d[5] = ra[1] * rb[0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = 63'(p2_q[2 * i]) - 63'(p2_q[2 * i + 1]);
      nw_d[i] = w[i][62];
      mw_d[i] = w[i][62] ? 62'(-w[i]) : 62'(w[i]);
    end
    wz_d = (w[0] == '0) && (w[1] == '0) && (w[2] == '0);
    for (int i = 0; i < 3; i++) begin
      mwx[i] = 64'(mw3_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FRONT_LAT; k++) ctl_q[k] <= '0;
    end else if (en_i) begin
      ctl_q[0].vld <= vld_i;
      ctl_q[0].dgn <= zero_d;
      ctl_q[1] <= ctl_q[0];
      ctl_q[2].vld <= ctl_q[1].vld;
      ctl_q[2].dgn <= ctl_q[1].dgn | wz_d;
      for (int k = 3; k < FRONT_LAT; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa1_q <= sa_d;
      sb1_q <= sb_d;
      for (int k = 0; k < 6; k++) p2_q[k] <= p_d[k];
      sa2_q <= sa1_q;
      sb2_q <= sb1_q;
      mw3_q <= mw_d;
      nw3_q <= nw_d;
      sa3_q <= sa2_q;
      sb3_q <= sb2_q;
      sm4_q[0] <= sa3_q;
      sm4_q[1] <= sb3_q;
      sm4_q[2] <= smv_scale(mwx, nw3_q);
      for (int v = 0; v < 3; v++) begin
        for (int i = 0; i < 3; i++) begin
          sq5_q[v][i] <= {30'b0, sm4_q[v].mag[i]} * {30'b0, sm4_q[v].mag[i]};
        end
        sm5_q[v] <= sm4_q[v];
        vec6_q[v].n2 <= 64'(sq5_q[v][0]) + 64'(sq5_q[v][1]) + 64'(sq5_q[v][2]);
        vec6_q[v].sm <= sm5_q[v];
      end
    end
  end

  assign ctl_o = ctl_q[FRONT_LAT-1];
  assign vec_o = vec6_q;

endmodule

### rtl/rbv_unit.sv
module rbv_unit (
  input  logic           clk_i,
  input  logic           en_i,
  input  rbv_pkg::vec_t  vec_i,
  output rbv_pkg::q30_t  u_o [3]
);
  import rbv_pkg::*;

  sq_t         sq_q  [SQRT_STEPS];
  smv_t        ssm_q [SQRT_STEPS];
  div_t        dv_q  [DIV_STEPS][3];
  logic [30:0] len_q [DIV_STEPS];
  logic [2:0]  dng_q [DIV_STEPS];

  sq_t         sq_in;
  logic [63:0] root;
  logic [30:0] len_d;

  always_comb begin
    sq_in.x = vec_i.n2;
    sq_in.r = '0;
    root = sq_q[SQRT_STEPS-1].r;
    len_d = (root == '0) ? 31'd1 : root[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0] <= sqrt_step(sq_in, 0);
      ssm_q[0] <= vec_i.sm;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq_q[k] <= sqrt_step(sq_q[k-1], k);
        ssm_q[k] <= ssm_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        dv_q[0][i] <= div_step(div_init(ssm_q[SQRT_STEPS-1].mag[i], len_d), len_d);
      end
      len_q[0] <= len_d;
      dng_q[0] <= ssm_q[SQRT_STEPS-1].neg;
      for (int k = 1; k < DIV_STEPS; k++) begin
        for (int i = 0; i < 3; i++) dv_q[k][i] <= div_step(dv_q[k-1][i], len_q[k-1]);
        len_q[k] <= len_q[k-1];
        dng_q[k] <= dng_q[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_o[i] = dng_q[DIV_STEPS-1][i] ? -q30_t'({1'b0, dv_q[DIV_STEPS-1][i].quo})
                                     : q30_t'({1'b0, dv_q[DIV_STEPS-1][i].quo});
    end
  end

endmodule

### rtl/rbv_back.sv
module rbv_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  rbv_pkg::ctl_t ctl_i,
  input  rbv_pkg::q30_t ua_i [3],
  input  rbv_pkg::q30_t ub_i [3],
  input  rbv_pkg::q30_t v_i [3],
  output rbv_pkg::ctl_t ctl_o,
  output rbv_pkg::q30_t m_o [3][3]
);
  import rbv_pkg::*;

  ctl_t ctl_q [BACK_LAT];

  logic signed [63:0] pd1_q [3];
  logic signed [63:0] pc1_q [6];
  q30_t               v1_q [3];

  logic signed [63:0] dsum;
  logic signed [34:0] dr;
  logic signed [34:0] xr [3];
  q30_t               c2_q;
  logic signed [32:0] x2_q [3];
  q30_t               v2_q [3];

  logic signed [65:0] xsq [3];
  logic [63:0]        xx3_q [3];
  logic signed [63:0] vv3_q [3][3];
  logic signed [32:0] t3_q;
  q30_t               c3_q;
  q30_t               v3_q [3];

  logic signed [34:0] vr [3][3];
  logic [63:0]        s24_q;
  logic signed [32:0] pv4_q [3][3];
  logic signed [32:0] t4_q;
  q30_t               c4_q;
  q30_t               v4_q [3];

  logic signed [63:0] pt5_q [3][3];
  logic [63:0]        s25_q;
  q30_t               c5_q;
  q30_t               v5_q [3];

  logic signed [34:0] pa6_q [3][3];
  logic [63:0]        s26_q;
  q30_t               v6_q [3];

  sq_t                sq_in;
  sq_t                sq_q [SQRT_STEPS];
  logic signed [34:0] pas_q [SQRT_STEPS][3][3];
  q30_t               vs_q [SQRT_STEPS][3];

  logic [63:0]        root;
  logic [30:0]        s_d;
  q30_t               kk [3][3];
  logic signed [63:0] sk_q [3][3];
  logic signed [34:0] pa_q [3][3];

  logic signed [34:0] e [3][3];
  q30_t               m_q [3][3];

  always_comb begin
    dsum = pd1_q[0] + pd1_q[1] + pd1_q[2];
    dr = rnd30(dsum);
    for (int i = 0; i < 3; i++) begin
      xr[i] = rnd30(pc1_q[2 * i] - pc1_q[2 * i + 1]);
      xsq[i] = x2_q[i] * x2_q[i];
      for (int j = 0; j < 3; j++) vr[i][j] = rnd30(vv3_q[i][j]);
    end
  end

  always_comb begin
    sq_in.x = s26_q;
    sq_in.r = '0;
    root = sq_q[SQRT_STEPS-1].r;
    s_d = (root > 64'(Q_ONE)) ? 31'(Q_ONE) : root[30:0];
    for (int i = 0; i < 3; i++) kk[i][i] = '0;
    kk[0][1] = -vs_q[SQRT_STEPS-1][2];
    kk[0][2] = vs_q[SQRT_STEPS-1][1];
    kk[1][0] = vs_q[SQRT_STEPS-1][2];
    kk[1][2] = -vs_q[SQRT_STEPS-1][0];
    kk[2][0] = -vs_q[SQRT_STEPS-1][1];
    kk[2][1] = vs_q[SQRT_STEPS-1][0];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) e[i][j] = pa_q[i][j] + rnd30(sk_q[i][j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BACK_LAT; k++) ctl_q[k] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int k = 1; k < BACK_LAT; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) pd1_q[i] <= ua_i[i] * ub_i[i];
      pc1_q[0] <= ua_i[1] * ub_i[2];
      pc1_q[1] <= ua_i[2] * ub_i[1];
      pc1_q[2] <= ua_i[2] * ub_i[0];
      pc1_q[3] <= ua_i[0] * ub_i[2];
      pc1_q[4] <= ua_i[0] * ub_i[1];
      pc1_q[5] <= ua_i[1] * ub_i[0];
      v1_q <= v_i;

      c2_q <= clamp_one(dr);
      for (int i = 0; i < 3; i++) x2_q[i] <= xr[i][32:0];
      v2_q <= v1_q;

      for (int i = 0; i < 3; i++) begin
        xx3_q[i] <= xsq[i][63:0];
        for (int j = 0; j < 3; j++) vv3_q[i][j] <= v2_q[i] * v2_q[j];
      end
      t3_q <= 33'(Q_ONE) - 33'(c2_q);
      c3_q <= c2_q;
      v3_q <= v2_q;

      s24_q <= xx3_q[0] + xx3_q[1] + xx3_q[2];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) pv4_q[i][j] <= vr[i][j][32:0];
      end
      t4_q <= t3_q;
      c4_q <= c3_q;
      v4_q <= v3_q;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) pt5_q[i][j] <= pv4_q[i][j] * t4_q;
      end
      s25_q <= s24_q;
      c5_q <= c4_q;
      v5_q <= v4_q;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pa6_q[i][j] <= rnd30(pt5_q[i][j]) + ((i == j) ? 35'(c5_q) : 35'sd0);
        end
      end
      s26_q <= s25_q;
      v6_q <= v5_q;

      sq_q[0] <= sqrt_step(sq_in, 0);
      pas_q[0] <= pa6_q;
      vs_q[0] <= v6_q;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq_q[k] <= sqrt_step(sq_q[k-1], k);
        pas_q[k] <= pas_q[k-1];
        vs_q[k] <= vs_q[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) sk_q[i][j] <= $signed({1'b0, s_d}) * kk[i][j];
      end
      pa_q <= pas_q[SQRT_STEPS-1];

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (ctl_q[BACK_LAT-2].dgn) m_q[i][j] <= (i == j) ? Q_ONE : '0;
          else m_q[i][j] <= clamp_one(e[i][j]);
        end
      end
    end
  end

  assign ctl_o = ctl_q[BACK_LAT-1];
  assign m_o = m_q;

endmodule

### rtl/rotation_between_vectors.sv
// Each item passes through rbv_front, the three rbv_unit pipelines, rbv_back and the output
// register, from which it is taken once out_stall_i is low.
// Throughput: one item per cycle while in_stall_o is low; the four 32-step square roots
// and the 31-step dividers are fully pipelined, one step per stage.
// Reset: rst_ni clears all valid bits, those of the output and skid registers too;
// datapath registers, output data included, are not reset. No clearing pass is needed.
module rotation_between_vectors (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [rbv_pkg::IN_WIDTH-1:0] from_x_i,
  input  logic signed [rbv_pkg::IN_WIDTH-1:0] from_y_i,
  input  logic signed [rbv_pkg::IN_WIDTH-1:0] from_z_i,
  input  logic signed [rbv_pkg::IN_WIDTH-1:0] to_x_i,
  input  logic signed [rbv_pkg::IN_WIDTH-1:0] to_y_i,
  input  logic signed [rbv_pkg::IN_WIDTH-1:0] to_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [31:0]                  m_row0_col0_o,
  output logic signed [31:0]                  m_row0_col1_o,
  output logic signed [31:0]                  m_row0_col2_o,
  output logic signed [31:0]                  m_row1_col0_o,
  output logic signed [31:0]                  m_row1_col1_o,
  output logic signed [31:0]                  m_row1_col2_o,
  output logic signed [31:0]                  m_row2_col0_o,
  output logic signed [31:0]                  m_row2_col1_o,
  output logic signed [31:0]                  m_row2_col2_o,
  output logic                                degenerate_o
);
  import rbv_pkg::*;

  logic                      en;
  logic [2:0][IN_WIDTH-1:0]  a_in, b_in;
  ctl_t                      ctl_f;
  vec_t                      vec_f [3];
  q30_t                      ua [3];
  q30_t                      ub [3];
  q30_t                      uw [3];
  ctl_t                      ud_q [UNIT_LAT];
  ctl_t                      ctl_b;
  q30_t                      m_b [3][3];

  logic                      free;
  logic                      out_vld_q, skid_vld_q;
  logic                      out_dg_q, skid_dg_q;
  q30_t                      out_m_q [3][3];
  q30_t                      skid_m_q [3][3];

  assign en = !skid_vld_q;
  assign in_stall_o = skid_vld_q;
  assign a_in = {from_z_i, from_y_i, from_x_i};
  assign b_in = {to_z_i, to_y_i, to_x_i};

  rbv_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .a_i    (a_in),
    .b_i    (b_in),
    .ctl_o  (ctl_f),
    .vec_o  (vec_f)
  );

  rbv_unit u_unit_a (.clk_i(clk_i), .en_i(en), .vec_i(vec_f[0]), .u_o(ua));
  rbv_unit u_unit_b (.clk_i(clk_i), .en_i(en), .vec_i(vec_f[1]), .u_o(ub));
  rbv_unit u_unit_w (.clk_i(clk_i), .en_i(en), .vec_i(vec_f[2]), .u_o(uw));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < UNIT_LAT; k++) ud_q[k] <= '0;
    end else if (en) begin
      ud_q[0] <= ctl_f;
      for (int k = 1; k < UNIT_LAT; k++) ud_q[k] <= ud_q[k-1];
    end
  end

  rbv_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ud_q[UNIT_LAT-1]),
    .ua_i   (ua),
    .ub_i   (ub),
    .v_i    (uw),
    .ctl_o  (ctl_b),
    .m_o    (m_b)
  );

  assign free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (free) begin
      out_vld_q <= skid_vld_q || ctl_b.vld;
      skid_vld_q <= 1'b0;
    end else if (en && ctl_b.vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      if (skid_vld_q) begin
        out_m_q <= skid_m_q;
        out_dg_q <= skid_dg_q;
      end else begin
        out_m_q <= m_b;
        out_dg_q <= ctl_b.dgn;
      end
    end else if (en && ctl_b.vld) begin
      skid_m_q <= m_b;
      skid_dg_q <= ctl_b.dgn;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign degenerate_o  = out_dg_q;
  assign m_row0_col0_o = out_m_q[0][0];
  assign m_row0_col1_o = out_m_q[0][1];
  assign m_row0_col2_o = out_m_q[0][2];
  assign m_row1_col0_o = out_m_q[1][0];
  assign m_row1_col1_o = out_m_q[1][1];
  assign m_row1_col2_o = out_m_q[1][2];
  assign m_row2_col0_o = out_m_q[2][0];
  assign m_row2_col1_o = out_m_q[2][1];
  assign m_row2_col2_o = out_m_q[2][2];

endmodule

### rtl/rbv_checker.sv
module rbv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               degenerate_o,
  input logic signed [31:0] m_row0_col0_o,
  input logic signed [31:0] m_row0_col1_o,
  input logic signed [31:0] m_row0_col2_o,
  input logic signed [31:0] m_row1_col0_o,
  input logic signed [31:0] m_row1_col1_o,
  input logic signed [31:0] m_row1_col2_o,
  input logic signed [31:0] m_row2_col0_o,
  input logic signed [31:0] m_row2_col1_o,
  input logic signed [31:0] m_row2_col2_o
);
  import rbv_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(m_row0_col0_o) && $stable(m_row1_col2_o)
      && $stable(m_row2_col1_o) && $stable(degenerate_o))
    else $error("stalled item changed");

  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> m_row0_col0_o == Q_ONE && m_row1_col1_o == Q_ONE
      && m_row2_col2_o == Q_ONE && m_row0_col1_o == 0 && m_row0_col2_o == 0
      && m_row1_col0_o == 0 && m_row1_col2_o == 0 && m_row2_col0_o == 0
      && m_row2_col1_o == 0)
    else $error("degenerate item is not identity");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> m_row0_col0_o <= Q_ONE && m_row0_col0_o >= -Q_ONE
      && m_row1_col1_o <= Q_ONE && m_row1_col1_o >= -Q_ONE
      && m_row2_col2_o <= Q_ONE && m_row2_col2_o >= -Q_ONE)
    else $error("diagonal entry out of range");

endmodule

bind rotation_between_vectors rbv_checker u_rbv_checker (.*);

### test/tb_rotation_between_vectors.sv
module tb_rotation_between_vectors;
  import rbv_pkg::*;

  localparam int LATENCY    = 110;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM   = 1300;
  localparam int CALM_TAIL  = 150;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic signed [31:0] fx, fy, fz, tx, ty, tz;
  } pair_t;

  typedef struct {
    logic signed [31:0] m[9];
    logic               dgn;
  } rot_t;

  typedef struct {
    pair_t p;
    logic  known;
    logic  dgn;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [31:0] from_x_i, from_y_i, from_z_i, to_x_i, to_y_i, to_z_i;
  logic signed [31:0] m_row0_col0_o, m_row0_col1_o, m_row0_col2_o;
  logic signed [31:0] m_row1_col0_o, m_row1_col1_o, m_row1_col2_o;
  logic signed [31:0] m_row2_col0_o, m_row2_col1_o, m_row2_col2_o;
  logic degenerate_o;

  rotation_between_vectors DUT (.*);

  rot_t rot_fifo[$];
  int   n_fail;
  int   idle_cycles;
  bit   sent_all;
  bit   calm;
  bit   hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int nbits(input logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b, x;
    x = v;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round30(input longint x);
    return (x + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint sat_one(input longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  // signed vector normalized so the largest magnitude sits in [2^29, 2^30)
  function automatic void norm_range(input longint a[3], output longint r[3]);
    logic [63:0] mg[3];
    logic [63:0] mx;
    int n;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = a[i] < 0 ? -a[i] : a[i];
      if (mg[i] > mx) mx = mg[i];
    end
    n = nbits(mx);
    for (int i = 0; i < 3; i++) begin
      mg[i] = n > 30 ? mg[i] >> (n - 30) : mg[i] << (30 - n);
      r[i] = a[i] < 0 ? -longint'(mg[i]) : longint'(mg[i]);
    end
  endfunction

  function automatic void unit_vec(input longint r[3], output longint u[3]);
    logic [63:0] mg[3];
    logic [63:0] n2, len, q;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = r[i] < 0 ? -r[i] : r[i];
      n2 += mg[i] * mg[i];
    end
    len = int_sqrt(n2);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << 30) + len / 2) / len;
      u[i] = r[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic rot_t predict_rotation(input pair_t p);
    rot_t   o;
    longint a[3], b[3], ra[3], rb[3], w[3], rw[3], ua[3], ub[3], v[3], x[3];
    longint k[3][3];
    longint c, s, t, e;
    logic [63:0] s2;
    a = '{p.fx, p.fy, p.fz};
    b = '{p.tx, p.ty, p.tz};
    o.dgn = (a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0);
    if (!o.dgn) begin
      norm_range(a, ra);
      norm_range(b, rb);
      w[0] = ra[1] * rb[2] - ra[2] * rb[1];
      w[1] = ra[2] * rb[0] - ra[0] * rb[2];
      w[2] = ra[0] * rb[1] - ra[1] * rb[0];
      o.dgn = (w[0] == 0 && w[1] == 0 && w[2] == 0);
    end
    if (o.dgn) begin
      for (int i = 0; i < 9; i++) o.m[i] = (i % 4 == 0) ? Q_ONE : 32'sd0;
      return o;
    end
    norm_range(w, rw);
    unit_vec(rw, v);
    unit_vec(ra, ua);
    unit_vec(rb, ub);
    c = sat_one(round30(ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2]));
    x[0] = round30(ua[1] * ub[2] - ua[2] * ub[1]);
    x[1] = round30(ua[2] * ub[0] - ua[0] * ub[2]);
    x[2] = round30(ua[0] * ub[1] - ua[1] * ub[0]);
    s2 = x[0] * x[0] + x[1] * x[1] + x[2] * x[2];
    s = longint'(int_sqrt(s2));
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    t = 64'sd1073741824 - c;
    k = '{'{0, -v[2], v[1]}, '{v[2], 0, -v[0]}, '{-v[1], v[0], 0}};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e = (i == j) ? c : 0;
        e += round30(round30(v[i] * v[j]) * t);
        e += round30(s * k[i][j]);
        o.m[i * 3 + j] = 32'(sat_one(e));
      end
    end
    return o;
  endfunction

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 65535)) - 32768;
      2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      3: return 0;
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int k;
    p = '{rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    case ($urandom_range(0, 9))
      0: begin
        k = $urandom_range(1, 3);
        p.tx = p.fx * k;
        p.ty = p.fy * k;
        p.tz = p.fz * k;
      end
      1: begin
        p.tx = -p.fx;
        p.ty = -p.fy;
        p.tz = -p.fz;
      end
      2: {p.tx, p.ty, p.tz} = '0;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pair(input pair_t p);
    while (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    {from_x_i, from_y_i, from_z_i} <= {p.fx, p.fy, p.fz};
    {to_x_i, to_y_i, to_z_i} <= {p.tx, p.ty, p.tz};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rot_fifo = {rot_fifo, predict_rotation(p)};
    @(negedge clk_i);
  endtask

  task automatic check_known(input pair_t p, input logic d);
    rot_t r;
    r = predict_rotation(p);
    if (r.dgn !== d) begin
      $error("directed degenerate expected %0b got %0b", d, r.dgn);
      n_fail++;
    end
  endtask

  localparam logic signed [31:0] MX = 32'sh7fff_ffff;
  localparam logic signed [31:0] MN = 32'sh8000_0000;
  localparam logic signed [31:0] ON = 32'sh0001_0000;

  row_t directed[] = '{
    '{'{0, 0, 0, ON, 0, 0}, 1, 1},
    '{'{ON, 0, 0, 0, 0, 0}, 1, 1},
    '{'{0, 0, 0, 0, 0, 0}, 1, 1},
    '{'{ON, 0, 0, ON, 0, 0}, 1, 1},
    '{'{ON, 0, 0, -ON, 0, 0}, 1, 1},
    '{'{MX, MX, MX, 1, 1, 1}, 1, 1},
    '{'{MN, 0, 0, MX, 0, 0}, 1, 1},
    '{'{MN, MN, MN, MN, MN, MN}, 1, 1},
    '{'{ON, 0, 0, 0, ON, 0}, 1, 0},
    '{'{0, ON, 0, 0, 0, ON}, 1, 0},
    '{'{0, 0, ON, ON, 0, 0}, 1, 0},
    '{'{MX, 0, 0, 0, MN, 0}, 1, 0},
    '{'{MN, MX, 0, 0, 0, MX}, 1, 0},
    '{'{1, 0, 0, 0, 1, 0}, 1, 0},
    '{'{-1, -1, -1, MX, MN, 1}, 0, 0},
    '{'{ON, ON, 0, ON, -ON, 0}, 0, 0},
    '{'{32'sh5555_5555, 32'shAAAA_AAAA, 1, 32'sh3333_3333, -7, MN}, 0, 0},
    '{'{ON, 1, 0, ON, 0, 0}, 0, 0},
    '{'{MX, MX, MX - 1, MX, MX, MX}, 0, 0}
  };

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    {from_x_i, from_y_i, from_z_i, to_x_i, to_y_i, to_z_i} = '0;
    n_fail = 0;
    sent_all = 0;
    calm = 0;
    hold_req = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed[i]) begin
      if (directed[i].known) check_known(directed[i].p, directed[i].dgn);
      send_pair(directed[i].p);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_req = 1;
      if (i == N_RANDOM - CALM_TAIL) calm = 1;
      send_pair(rand_pair());
    end
    in_valid_i <= 1'b0;
    sent_all = 1;
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    rot_t got, want;
    string names[9];
    names = '{"m_row0_col0", "m_row0_col1", "m_row0_col2", "m_row1_col0", "m_row1_col1",
              "m_row1_col2", "m_row2_col0", "m_row2_col1", "m_row2_col2"};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.m = '{m_row0_col0_o, m_row0_col1_o, m_row0_col2_o, m_row1_col0_o, m_row1_col1_o,
                m_row1_col2_o, m_row2_col0_o, m_row2_col1_o, m_row2_col2_o};
      got.dgn = degenerate_o;
      if (rot_fifo.size() == 0) begin
        $error("result item with no expectation pending");
        n_fail++;
      end else begin
        want = rot_fifo.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got.m[i] !== want.m[i]) begin
            $error("%s expected %0d actual %0d", names[i], want.m[i], got.m[i]);
            n_fail++;
          end
        end
        if (got.dgn !== want.dgn) begin
          $error("degenerate expected %0b actual %0b", want.dgn, got.dgn);
          n_fail++;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
      if (sent_all && rot_fifo.size() == 0) begin
        repeat (LATENCY + 20) @(posedge clk_i);
        if (n_fail == 0) begin
          $display("[ OK ] regression clean");
        end else begin
          $display("[FAIL] regression broken");
        end
        $finish;
      end
    end
  end

endmodule

### files.f
rtl/rbv_pkg.sv
rtl/rbv_front.sv
rtl/rbv_unit.sv
rtl/rbv_back.sv
rtl/rotation_between_vectors.sv
rtl/rbv_checker.sv
test/tb_rotation_between_vectors.sv
